// ----- hdl/jqbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jqbp_pkg
// shared types and constants of the json query body parser
// ----------------------------------------------------------------------------
package jqbp_pkg;

    typedef enum logic [3:0] {
        PH_OPEN         = 4'd0,
        PH_KEY_OR_CLOSE = 4'd1,
        PH_STR          = 4'd2,
        PH_COLON        = 4'd3,
        PH_VALUE        = 4'd4,
        PH_NEST         = 4'd5,
        PH_LIT          = 4'd6,
        PH_AFTER        = 4'd7,
        PH_DONE         = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_KEY    = 2'd0,
        ROLE_VALUE  = 2'd1,
        ROLE_SKIP   = 2'd2,
        ROLE_NESTED = 2'd3
    } role_t;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_UNSUPP  = 2'd2;

    // result word handed from the parser core to the output register
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic       target;
        logic [7:0] data;
        logic [1:0] status;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] name_sql(input logic [3:0] i);
        case (i)
            4'd0:    return 8'h73;
            4'd1:    return 8'h71;
            4'd2:    return 8'h6C;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] name_rid(input logic [3:0] i);
        case (i)
            4'd0:    return 8'h72;
            4'd1:    return 8'h65;
            4'd2:    return 8'h71;
            4'd3:    return 8'h75;
            4'd4:    return 8'h65;
            4'd5:    return 8'h73;
            4'd6:    return 8'h74;
            4'd7:    return 8'h5F;
            4'd8:    return 8'h69;
            4'd9:    return 8'h64;
            default: return 8'h00;
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- hdl/jqbp_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jqbp_core
// parser state and next-state logic, one body byte per step
// ----------------------------------------------------------------------------
module jqbp_core #(
    parameter int MAX_DEPTH = 64,
    parameter int DW        = 7
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 step,
    input  wire  [7:0]          body_byte,
    input  wire                 body_end,
    input  wire                 media_is_json,
    output jqbp_pkg::result_t   res
);

    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

    jqbp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]    esc_reg, esc_next;
    logic          hz_reg, hz_next;
    logic [7:0]    hl_reg, hl_next;
    jqbp_pkg::role_t role_reg, role_next;
    logic [3:0]    kpos_reg, kpos_next;
    logic          ksql_reg, ksql_next, krid_reg, krid_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic          comma_reg, comma_next, fail_reg, fail_next;
    logic          seen_reg, seen_next, inq_reg, inq_next;
    logic          semi_reg, semi_next, cont_reg, cont_next, tail_reg, tail_next;

    // string byte decode results
    logic       s_fail, s_dec, s_close;
    logic [7:0] s_d;
    logic [3:0] hexv;
    logic       hexok;
    logic [7:0] hl_shift;

    logic       got;
    logic [1:0] g_kind;
    logic       g_target;
    logic [7:0] g_data;
    logic       bad;

    always_comb begin
        hexok = 1'b1;
        hexv  = 4'd0;
        if (body_byte >= 8'h30 && body_byte <= 8'h39) begin
            hexv = 4'(body_byte - 8'h30);
        end else if (body_byte >= 8'h61 && body_byte <= 8'h66) begin
            hexv = 4'(body_byte - 8'h57);
        end else if (body_byte >= 8'h41 && body_byte <= 8'h46) begin
            hexv = 4'(body_byte - 8'h37);
        end else begin
            hexok = 1'b0;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        hz_next    = hz_reg;
        hl_next    = hl_reg;
        role_next  = role_reg;
        kpos_next  = kpos_reg;
        ksql_next  = ksql_reg;
        krid_next  = krid_reg;
        depth_next = depth_reg;
        comma_next = comma_reg;
        fail_next  = fail_reg;
        seen_next  = seen_reg;
        inq_next   = inq_reg;
        semi_next  = semi_reg;
        cont_next  = cont_reg;
        tail_next  = tail_reg;
        s_fail = 1'b0; s_dec = 1'b0; s_close = 1'b0; s_d = 8'd0;
        hl_shift = {hl_reg[3:0], hexv};
        got = 1'b0; g_kind = jqbp_pkg::KIND_START; g_target = 1'b0; g_data = 8'd0;

        // string byte decoder
        if (esc_reg == 3'd0) begin
            if (body_byte == 8'h22) s_close = 1'b1;
            else if (body_byte < 8'h20) s_fail = 1'b1;
            else if (body_byte == 8'h5C) esc_next = 3'd1;
            else begin s_dec = 1'b1; s_d = body_byte; end
        end else if (esc_reg == 3'd1) begin
            esc_next = 3'd0;
            s_dec = 1'b1;
            case (body_byte)
                8'h22: s_d = 8'h22;
                8'h5C: s_d = 8'h5C;
                8'h2F: s_d = 8'h2F;
                8'h62: s_d = 8'h08;
                8'h66: s_d = 8'h0C;
                8'h6E: s_d = 8'h0A;
                8'h72: s_d = 8'h0D;
                8'h74: s_d = 8'h09;
                8'h75: begin
                    s_dec = 1'b0; esc_next = 3'd2; hz_next = 1'b1; hl_next = 8'd0;
                end
                default: begin s_dec = 1'b0; s_fail = 1'b1; end
            endcase
        end else begin
            if (!hexok) s_fail = 1'b1;
            else begin
                if (esc_reg <= 3'd3) begin
                    if (hexv != 4'd0) hz_next = 1'b0;
                end else begin
                    hl_next = hl_shift;
                end
                if (esc_reg >= 3'd5) begin
                    esc_next = 3'd0;
                    s_dec = 1'b1;
                    s_d = (hz_reg && hl_shift != 8'd0 && !hl_shift[7]) ? hl_shift : 8'h3F;
                end else begin
                    esc_next = esc_reg + 3'd1;
                end
            end
        end
        // decoder state only commits in the string phase
        if (phase_reg != jqbp_pkg::PH_STR) begin
            esc_next = esc_reg; hz_next = hz_reg; hl_next = hl_reg;
        end

        if (!fail_reg) begin
            if (body_byte == 8'd0) begin
                if (!body_end) fail_next = 1'b1;
            end else begin
                unique case (phase_reg)
                    jqbp_pkg::PH_OPEN: begin
                        if (!jqbp_pkg::is_ws(body_byte)) begin
                            if (body_byte == 8'h7B) begin
                                phase_next = jqbp_pkg::PH_KEY_OR_CLOSE;
                                comma_next = 1'b0;
                            end else fail_next = 1'b1;
                        end
                    end
                    jqbp_pkg::PH_KEY_OR_CLOSE: begin
                        if (!jqbp_pkg::is_ws(body_byte)) begin
                            if (body_byte == 8'h7D && !comma_reg) begin
                                phase_next = jqbp_pkg::PH_DONE;
                            end else if (body_byte == 8'h22) begin
                                comma_next = 1'b0;
                                role_next  = jqbp_pkg::ROLE_KEY;
                                kpos_next  = 4'd0;
                                ksql_next  = 1'b1;
                                krid_next  = 1'b1;
                                esc_next   = 3'd0;
                                phase_next = jqbp_pkg::PH_STR;
                            end else fail_next = 1'b1;
                        end
                    end
                    jqbp_pkg::PH_STR: begin
                        if (s_fail) fail_next = 1'b1;
                        else if (s_close) begin
                            case (role_reg)
                                jqbp_pkg::ROLE_KEY: begin
                                    if (kpos_reg != 4'd3) ksql_next = 1'b0;
                                    if (kpos_reg != 4'd10) krid_next = 1'b0;
                                    phase_next = jqbp_pkg::PH_COLON;
                                end
                                jqbp_pkg::ROLE_NESTED: phase_next = jqbp_pkg::PH_NEST;
                                default: phase_next = jqbp_pkg::PH_AFTER;
                            endcase
                        end else if (s_dec) begin
                            if (role_reg == jqbp_pkg::ROLE_KEY) begin
                                if (!(kpos_reg < 4'd3 && s_d == jqbp_pkg::name_sql(kpos_reg)))
                                    ksql_next = 1'b0;
                                if (!(kpos_reg < 4'd10 && s_d == jqbp_pkg::name_rid(kpos_reg)))
                                    krid_next = 1'b0;
                                if (kpos_reg < 4'd15) kpos_next = kpos_reg + 4'd1;
                            end else if (role_reg == jqbp_pkg::ROLE_VALUE) begin
                                got = 1'b1;
                                g_kind = jqbp_pkg::KIND_BYTE;
                                g_target = krid_reg;
                                g_data = s_d;
                                if (!krid_reg) begin
                                    if (semi_reg) begin
                                        if (!jqbp_pkg::is_ws(s_d)) tail_next = 1'b1;
                                    end else if (s_d == 8'h27) inq_next = ~inq_reg;
                                    else if (!inq_reg && s_d == 8'h3B) semi_next = 1'b1;
                                    else if (!jqbp_pkg::is_ws(s_d)) cont_next = 1'b1;
                                end
                            end
                        end
                    end
                    jqbp_pkg::PH_COLON: begin
                        if (!jqbp_pkg::is_ws(body_byte)) begin
                            if (body_byte == 8'h3A) phase_next = jqbp_pkg::PH_VALUE;
                            else fail_next = 1'b1;
                        end
                    end
                    jqbp_pkg::PH_VALUE: begin
                        if (!jqbp_pkg::is_ws(body_byte)) begin
                            esc_next = 3'd0;
                            if (ksql_reg || krid_reg) begin
                                if (body_byte != 8'h22) fail_next = 1'b1;
                                else begin
                                    role_next  = jqbp_pkg::ROLE_VALUE;
                                    phase_next = jqbp_pkg::PH_STR;
                                    got = 1'b1;
                                    g_kind = jqbp_pkg::KIND_START;
                                    g_target = krid_reg;
                                    if (!krid_reg) begin
                                        seen_next = 1'b1; inq_next = 1'b0;
                                        semi_next = 1'b0; cont_next = 1'b0;
                                        tail_next = 1'b0;
                                    end
                                end
                            end else if (body_byte == 8'h22) begin
                                role_next  = jqbp_pkg::ROLE_SKIP;
                                phase_next = jqbp_pkg::PH_STR;
                            end else if (body_byte == 8'h7B || body_byte == 8'h5B) begin
                                depth_next = DW'(1);
                                phase_next = jqbp_pkg::PH_NEST;
                            end else if (body_byte == 8'h2C || body_byte == 8'h7D
                                         || body_byte == 8'h5D) begin
                                fail_next = 1'b1;
                            end else phase_next = jqbp_pkg::PH_LIT;
                        end
                    end
                    jqbp_pkg::PH_NEST: begin
                        if (body_byte == 8'h22) begin
                            role_next = jqbp_pkg::ROLE_NESTED;
                            esc_next = 3'd0;
                            phase_next = jqbp_pkg::PH_STR;
                        end else if (body_byte == 8'h7B || body_byte == 8'h5B) begin
                            if (depth_reg >= DEPTH_MAX) fail_next = 1'b1;
                            else depth_next = depth_reg + DW'(1);
                        end else if (body_byte == 8'h7D || body_byte == 8'h5D) begin
                            if (depth_reg <= DW'(1)) begin
                                depth_next = '0;
                                phase_next = jqbp_pkg::PH_AFTER;
                            end else depth_next = depth_reg - DW'(1);
                        end
                    end
                    jqbp_pkg::PH_LIT, jqbp_pkg::PH_AFTER: begin
                        if (phase_reg == jqbp_pkg::PH_AFTER || jqbp_pkg::is_ws(body_byte)
                            || body_byte == 8'h2C || body_byte == 8'h7D
                            || body_byte == 8'h5D) begin
                            phase_next = jqbp_pkg::PH_AFTER;
                            if (jqbp_pkg::is_ws(body_byte)) begin
                            end else if (body_byte == 8'h2C) begin
                                comma_next = 1'b1;
                                phase_next = jqbp_pkg::PH_KEY_OR_CLOSE;
                            end else if (body_byte == 8'h7D) begin
                                phase_next = jqbp_pkg::PH_DONE;
                            end else fail_next = 1'b1;
                        end
                    end
                    jqbp_pkg::PH_DONE: begin
                        if (!jqbp_pkg::is_ws(body_byte)) fail_next = 1'b1;
                    end
                    default: fail_next = 1'b1;
                endcase
            end
        end else begin
            esc_next = esc_reg; hz_next = hz_reg; hl_next = hl_reg;
        end

        bad = fail_next || phase_next != jqbp_pkg::PH_DONE || !seen_next || inq_next
              || !cont_next || (semi_next && tail_next);

        res = '0;
        if (body_end) begin
            res.valid  = 1'b1;
            res.kind   = jqbp_pkg::KIND_STATUS;
            res.status = !media_is_json ? jqbp_pkg::ST_UNSUPP
                       : (bad ? jqbp_pkg::ST_BAD : jqbp_pkg::ST_OK);
        end else if (got && !fail_next) begin
            res.valid  = 1'b1;
            res.kind   = g_kind;
            res.target = g_target;
            res.data   = g_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && body_end)) begin
            phase_reg <= jqbp_pkg::PH_OPEN;
            esc_reg   <= 3'd0;
            hz_reg    <= 1'b1;
            hl_reg    <= 8'd0;
            role_reg  <= jqbp_pkg::ROLE_KEY;
            kpos_reg  <= 4'd0;
            ksql_reg  <= 1'b1;
            krid_reg  <= 1'b1;
            depth_reg <= '0;
            comma_reg <= 1'b0;
            fail_reg  <= 1'b0;
            seen_reg  <= 1'b0;
            inq_reg   <= 1'b0;
            semi_reg  <= 1'b0;
            cont_reg  <= 1'b0;
            tail_reg  <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            hz_reg    <= hz_next;
            hl_reg    <= hl_next;
            role_reg  <= role_next;
            kpos_reg  <= kpos_next;
            ksql_reg  <= ksql_next;
            krid_reg  <= krid_next;
            depth_reg <= depth_next;
            comma_reg <= comma_next;
            fail_reg  <= fail_next;
            seen_reg  <= seen_next;
            inq_reg   <= inq_next;
            semi_reg  <= semi_next;
            cont_reg  <= cont_next;
            tail_reg  <= tail_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/jqbp_out.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jqbp_out
// two-entry output buffer, full rate with registered ready
// ----------------------------------------------------------------------------
module jqbp_out (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    input  jqbp_pkg::result_t   in_res,
    output logic                in_ready,
    output logic                out_valid,
    output jqbp_pkg::result_t   out_res,
    input  wire                 out_ready
);

    jqbp_pkg::result_t main_reg, skid_reg;
    logic main_v_reg, skid_v_reg;

    assign in_ready  = !skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_res   = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (!main_v_reg || out_ready) begin
                if (skid_v_reg) begin
                    main_v_reg <= 1'b1;
                    skid_v_reg <= 1'b0;
                end else begin
                    main_v_reg <= in_valid;
                end
            end else if (in_valid && !skid_v_reg) begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_v_reg || out_ready) begin
            main_reg <= skid_v_reg ? skid_reg : in_res;
        end
        if (!skid_v_reg) skid_reg <= in_res;
    end

endmodule
`default_nettype wire

// ----- hdl/json_query_body_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_query_body_parser
// checks a request body as one json object and streams the sql and
// request id values, then a final status word
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                 | tuser / tlast
// s_      | in  | body_byte[7:0]                     | tuser media_is_json, tlast body_end
// m_      | out | value_target, value_data, status   | tuser result_kind[1:0]
//
// one body word per cycle while s_tready is high; the parser step is a single pass of logic
// between the parser state registers and a two-entry output buffer
// a result word reaches m_ from the output buffer's main register, passing through its skid register first if m_ stalls
// reset (aresetn low, synchronous) returns to "expect opening brace"
// a stalled output holds the result and deasserts s_tready once the
// buffer is full, so no word is lost
// ----------------------------------------------------------------------------
module json_query_body_parser #(
    parameter int MAX_DEPTH = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // body_byte
    input  wire         s_tuser,   // media_is_json
    input  wire         s_tlast,   // body_end
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // value_target, value_data[8:1], parse_status[10:9]
    output logic [1:0]  m_tuser    // result_kind
);

    // depth counter holds 0..MAX_DEPTH
    localparam int DW = $clog2(MAX_DEPTH + 1);

    jqbp_pkg::result_t core_res, buf_res;
    logic step, buf_valid;

    assign step = s_tvalid && s_tready;

    jqbp_core #(.MAX_DEPTH(MAX_DEPTH), .DW(DW)) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .body_byte     (s_tdata),
        .body_end      (s_tlast),
        .media_is_json (s_tuser),
        .res           (core_res)
    );

    jqbp_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (step && core_res.valid),
        .in_res    (core_res),
        .in_ready  (s_tready),
        .out_valid (buf_valid),
        .out_res   (buf_res),
        .out_ready (m_tready)
    );

    assign m_tvalid = buf_valid;
    assign m_tuser  = buf_res.kind;
    assign m_tdata  = {5'd0, buf_res.status, buf_res.data, buf_res.target};

endmodule
`default_nettype wire
